@@ hdl/jsfp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsfp_pkg
// Shared types, constants and the marker code classifier for the JPEG SOF
// precision finder.
// ----------------------------------------------------------------------------
package jsfp_pkg;

   localparam int ByteW   = 8;
   localparam int StatusW = 2;
   localparam int SkipW   = 16;

   // Marker prefix and code bytes (the code is the byte after the FF prefix).
   localparam logic [ByteW-1:0] MARKER_PREFIX = 8'hFF;
   localparam logic [ByteW-1:0] CODE_SOF_LO   = 8'hC0;
   localparam logic [ByteW-1:0] CODE_SOF_HI   = 8'hCF;
   localparam logic [ByteW-1:0] CODE_DHT      = 8'hC4;
   localparam logic [ByteW-1:0] CODE_JPG      = 8'hC8;
   localparam logic [ByteW-1:0] CODE_DAC      = 8'hCC;
   localparam logic [ByteW-1:0] CODE_RST0     = 8'hD0;
   localparam logic [ByteW-1:0] CODE_EOI      = 8'hD9;
   localparam logic [ByteW-1:0] CODE_SOS      = 8'hDA;
   localparam logic [ByteW-1:0] CODE_TEM      = 8'h01;
   localparam logic [ByteW-1:0] CODE_RES_LO   = 8'h03;
   localparam logic [ByteW-1:0] CODE_RES_HI   = 8'hBF;

   localparam logic [SkipW-1:0] LEN_HEADER = 16'd2;

   typedef enum logic [2:0] {
      PH_PREFIX    = 3'd0,
      PH_CODE      = 3'd1,
      PH_LEN_HI    = 3'd2,
      PH_LEN_LO    = 3'd3,
      PH_SKIP      = 3'd4,
      PH_PRECISION = 3'd5
   } phase_type;

   typedef enum logic [StatusW-1:0] {
      ST_FOUND   = 2'd0,
      ST_INVALID = 2'd1,
      ST_ENDED   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      MC_INVALID    = 3'd0,
      MC_STANDALONE = 3'd1,
      MC_SEGMENT    = 3'd2,
      MC_SOF        = 3'd3,
      MC_FILL       = 3'd4
   } marker_class_type;

   // One byte transaction presented to the parser.
   typedef struct packed {
      logic             fire;
      logic [ByteW-1:0] data_byte;
      logic             last_byte;
   } item_type;

   // Parser verdict for the current byte.
   typedef struct packed {
      logic             fin;
      logic [ByteW-1:0] bit_depth;
      status_type       scan_status;
   } verdict_type;

   function automatic marker_class_type classify(input logic [ByteW-1:0] code);
      marker_class_type mc;
      mc = MC_INVALID;
      if (code == MARKER_PREFIX) begin
         mc = MC_FILL;
      end else if (code >= CODE_SOF_LO && code <= CODE_SOF_HI) begin
         if (code == CODE_DHT || code == CODE_JPG || code == CODE_DAC) begin
            mc = MC_SEGMENT;
         end else begin
            mc = MC_SOF;
         end
      end else if (code >= CODE_RST0 && code <= CODE_EOI) begin
         mc = MC_STANDALONE;
      end else if (code >= CODE_SOS) begin
         mc = MC_SEGMENT;
      end else if (code == CODE_TEM) begin
         mc = MC_STANDALONE;
      end else if (code >= CODE_RES_LO && code <= CODE_RES_HI) begin
         mc = MC_STANDALONE;
      end
      return mc;
   endfunction

endpackage

@@ hdl/jpeg_sof_precision_finder_top.sv @@
`timescale 1ns / 1ps
// Result path: the deciding byte is taken into the input register, then passes the parser
// into the result register, which drives rsp_valid; a stalled result can hold it in between.
// Throughput: 1 byte per cycle sustained while no result is stalled by rsp_ready.
// Critical path: marker classify plus 16-bit length compare/subtract.
// Reset: synchronous, active high; parser returns to expecting an FF prefix,
// the input and result registers are emptied.
// ----------------------------------------------------------------------------
// jpeg_sof_precision_finder_top
// Walks JPEG markers and reports the precision byte of the first SOF segment,
// one result transaction per image.
// ----------------------------------------------------------------------------
module jpeg_sof_precision_finder_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [jsfp_pkg::ByteW-1:0]     req_data_byte,
   input  logic                           req_last_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [jsfp_pkg::ByteW-1:0]     rsp_bit_depth,
   output logic [jsfp_pkg::StatusW-1:0]   rsp_scan_status
);

   // input register stage
   logic                          in_valid_ff;
   logic [jsfp_pkg::ByteW-1:0]    in_data_ff;
   logic                          in_last_ff;

   // result register stage
   logic                          out_valid_ff;
   logic [jsfp_pkg::ByteW-1:0]    out_depth_ff;
   jsfp_pkg::status_type          out_status_ff;

   logic                          advance;
   jsfp_pkg::item_type            item;
   jsfp_pkg::verdict_type         verdict;

   // Held byte moves through the parser when the result slot is free or is
   // being drained this cycle; the input register refills in the same cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   assign item.fire      = advance;
   assign item.data_byte = in_data_ff;
   assign item.last_byte = in_last_ff;

   jsfp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .item    (item),
      .verdict (verdict)
   );

   // result register: loaded only when the byte decides the image
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && verdict.fin) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && verdict.fin) begin
         out_depth_ff  <= verdict.bit_depth;
         out_status_ff <= verdict.scan_status;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_bit_depth   = out_depth_ff;
   assign rsp_scan_status = out_status_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> ($stable(out_depth_ff) && $stable(out_status_ff)))
      else $error("pending result overwritten");

   a_no_fire_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |-> !advance)
      else $error("parser advanced while result stalled");

   a_found_status_only: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_status_ff != jsfp_pkg::ST_FOUND) |-> (out_depth_ff == '0))
      else $error("nonzero depth without SOF");

endmodule

@@ hdl/jsfp_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsfp_parser
// Marker walk state machine: one byte per cycle while item.fire is high, flags the decision.
// ----------------------------------------------------------------------------
module jsfp_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  jsfp_pkg::item_type    item,
   output jsfp_pkg::verdict_type verdict
);

   jsfp_pkg::phase_type              phase_ff, phase_in;
   logic [jsfp_pkg::SkipW-1:0]       skip_ff, skip_in;
   logic [jsfp_pkg::ByteW-1:0]       len_hi_ff, len_hi_in;
   logic                             frame_ff, frame_in;
   logic                             decided_ff, decided_in;

   jsfp_pkg::marker_class_type       mc;
   logic [jsfp_pkg::SkipW-1:0]       seg_len;
   logic [jsfp_pkg::SkipW-1:0]       skip_dec;
   logic                             fin;
   logic [jsfp_pkg::ByteW-1:0]       depth;
   jsfp_pkg::status_type             status;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= jsfp_pkg::PH_PREFIX;
         skip_ff    <= '0;
         len_hi_ff  <= '0;
         frame_ff   <= 1'b0;
         decided_ff <= 1'b0;
      end else if (item.fire) begin
         phase_ff   <= phase_in;
         skip_ff    <= skip_in;
         len_hi_ff  <= len_hi_in;
         frame_ff   <= frame_in;
         decided_ff <= decided_in;
      end
   end

   always_comb begin
      mc       = jsfp_pkg::classify(item.data_byte);
      seg_len  = {len_hi_ff, item.data_byte};
      skip_dec = skip_ff - 16'd1;

      phase_in   = phase_ff;
      skip_in    = skip_ff;
      len_hi_in  = len_hi_ff;
      frame_in   = frame_ff;
      decided_in = decided_ff;
      fin        = 1'b0;
      depth      = '0;
      status     = jsfp_pkg::ST_INVALID;

      if (!decided_ff) begin
         unique case (phase_ff)
            jsfp_pkg::PH_PREFIX: begin
               if (item.data_byte == jsfp_pkg::MARKER_PREFIX) begin
                  phase_in = jsfp_pkg::PH_CODE;
               end else begin
                  fin = 1'b1;
               end
            end
            jsfp_pkg::PH_CODE: begin
               unique case (mc)
                  jsfp_pkg::MC_INVALID:    fin = 1'b1;
                  jsfp_pkg::MC_STANDALONE: phase_in = jsfp_pkg::PH_PREFIX;
                  jsfp_pkg::MC_FILL:       phase_in = jsfp_pkg::PH_CODE;
                  jsfp_pkg::MC_SEGMENT,
                  jsfp_pkg::MC_SOF: begin
                     frame_in = (mc == jsfp_pkg::MC_SOF);
                     phase_in = jsfp_pkg::PH_LEN_HI;
                  end
                  default:                 fin = 1'b1;
               endcase
            end
            jsfp_pkg::PH_LEN_HI: begin
               len_hi_in = item.data_byte;
               phase_in  = jsfp_pkg::PH_LEN_LO;
            end
            jsfp_pkg::PH_LEN_LO: begin
               priority if (frame_ff) begin
                  phase_in = jsfp_pkg::PH_PRECISION;
               end else if (seg_len < jsfp_pkg::LEN_HEADER) begin
                  fin = 1'b1;
               end else if (seg_len == jsfp_pkg::LEN_HEADER) begin
                  phase_in = jsfp_pkg::PH_PREFIX;
               end else begin
                  skip_in  = seg_len - jsfp_pkg::LEN_HEADER;
                  phase_in = jsfp_pkg::PH_SKIP;
               end
            end
            jsfp_pkg::PH_SKIP: begin
               skip_in = skip_dec;
               if (skip_dec == '0) begin
                  phase_in = jsfp_pkg::PH_PREFIX;
               end
            end
            jsfp_pkg::PH_PRECISION: begin
               fin    = 1'b1;
               depth  = item.data_byte;
               status = jsfp_pkg::ST_FOUND;
            end
            default: phase_in = jsfp_pkg::PH_PREFIX;
         endcase

         if (!fin && item.last_byte) begin
            fin    = 1'b1;
            depth  = '0;
            status = jsfp_pkg::ST_ENDED;
         end
         if (fin) begin
            decided_in = 1'b1;
         end
      end

      // last byte restarts the walk for the next image
      if (item.last_byte) begin
         phase_in   = jsfp_pkg::PH_PREFIX;
         skip_in    = '0;
         len_hi_in  = '0;
         frame_in   = 1'b0;
         decided_in = 1'b0;
      end

      verdict.fin         = fin;
      verdict.bit_depth   = depth;
      verdict.scan_status = status;
   end

   a_no_second_result: assert property (@(posedge clock) disable iff (reset)
      (item.fire && decided_ff) |-> !verdict.fin)
      else $error("second result for one image");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (item.fire && item.last_byte) |=> (phase_ff == jsfp_pkg::PH_PREFIX && !decided_ff))
      else $error("parser not restarted after last byte");

   a_skip_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == jsfp_pkg::PH_SKIP) |-> (skip_ff != '0))
      else $error("skip phase with empty count");

   a_decide_sticks: assert property (@(posedge clock) disable iff (reset)
      (item.fire && verdict.fin && !item.last_byte) |=> decided_ff)
      else $error("decision not recorded");

endmodule
